### sv/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared item types, parser phase codes and constants.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Width of the message length limit register.
  localparam int unsigned MaxLenW = 24;

  // Seven-bit length codes of the second header byte.
  localparam logic [6:0] SHORT_LEN_MAX = 7'd125;
  localparam logic [6:0] EXT16_CODE    = 7'd126;

  // Extension and key byte counts, minus one.
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  // Register reset values.
  localparam logic [MaxLenW-1:0] MAX_LEN_RESET = MaxLenW'(8 * 1024 * 1024);
  localparam logic               REQ_MASK_RESET = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MAX_LEN  = 1'b0;
  localparam logic CFG_REQ_MASK = 1'b1;

  // Error codes reported with a result.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNMASKED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_HDR1    = 5'b00001,
    PH_HDR2    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } wsfr_phase_e;

  // One received byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_connection;
  } wsfr_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       data_valid;
    logic [3:0] msg_opcode;
    logic       fin_flag;
    logic       frame_end;
    logic [1:0] error_code;
  } wsfr_out_t;

  // Result of one parser step.
  typedef struct packed {
    logic      valid;
    wsfr_out_t item;
  } wsfr_res_t;

endpackage
`default_nettype wire

### sv/wsfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header, length, key and message state and turns one accepted
// byte into zero or one result in the same cycle.
// ----------------------------------------------------------------------------
module wsfr_parser import wsfr_pkg::*; #(
  parameter int unsigned LEN_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [MaxLenW-1:0] cfg_data_i,
  input  wire logic               accept_i,
  input  wire wsfr_in_t           item_i,
  output wsfr_res_t               res_o
);

  localparam int unsigned SumW = ((LEN_BITS > MaxLenW) ? LEN_BITS : MaxLenW) + 1;

  // Configuration registers.
  logic [MaxLenW-1:0] max_len_q;
  logic               req_mask_q;

  // Parser state.
  wsfr_phase_e         phase_q, phase_d;
  logic [2:0]          hcnt_q, hcnt_d;
  logic                fin_q, fin_d;
  logic [3:0]          opc_q, opc_d;
  logic                masked_q, masked_d;
  logic [MaxLenW-1:0]  rlen_q, rlen_d;
  logic                rovf_q, rovf_d;
  logic [31:0]         key_q, key_d;
  logic [1:0]          midx_q, midx_d;
  logic [3:0]          mtype_q, mtype_d;
  logic [LEN_BITS-1:0] mlen_q, mlen_d;
  logic                closed_q, closed_d;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MAX_LEN_RESET;
      req_mask_q <= REQ_MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LEN:  max_len_q  <= cfg_data_i;
        CFG_REQ_MASK: req_mask_q <= cfg_data_i[0];
        default:      max_len_q  <= max_len_q;
      endcase
    end
  end

  // One parser step for the accepted byte.
  always_comb begin
    logic [7:0]     b;
    logic           len_known;
    logic           start_pay;
    logic           too_long;
    logic [SumW-1:0] msg_sum;
    logic [7:0]     kbyte;

    b         = item_i.in_byte;
    len_known = 1'b0;
    start_pay = 1'b0;
    too_long  = 1'b0;
    msg_sum   = '0;
    kbyte     = 8'd0;

    res_o.valid             = 1'b0;
    res_o.item.payload_byte = 8'd0;
    res_o.item.data_valid   = 1'b0;
    res_o.item.msg_opcode   = 4'd0;
    res_o.item.fin_flag     = 1'b0;
    res_o.item.frame_end    = 1'b0;
    res_o.item.error_code   = ERR_NONE;

    // A new connection clears the state before the byte is parsed.
    if (item_i.new_connection) begin
      phase_d  = PH_HDR1;
      hcnt_d   = 3'd0;
      fin_d    = 1'b0;
      opc_d    = 4'd0;
      masked_d = 1'b0;
      rlen_d   = '0;
      rovf_d   = 1'b0;
      key_d    = 32'd0;
      midx_d   = 2'd0;
      mtype_d  = 4'd0;
      mlen_d   = '0;
      closed_d = 1'b0;
    end else begin
      phase_d  = phase_q;
      hcnt_d   = hcnt_q;
      fin_d    = fin_q;
      opc_d    = opc_q;
      masked_d = masked_q;
      rlen_d   = rlen_q;
      rovf_d   = rovf_q;
      key_d    = key_q;
      midx_d   = midx_q;
      mtype_d  = mtype_q;
      mlen_d   = mlen_q;
      closed_d = closed_q;
    end

    if (!closed_d) begin
      case (phase_d)
        PH_HDR2: begin
          masked_d = b[7];
          if (!b[7] && req_mask_q) begin
            closed_d              = 1'b1;
            phase_d               = PH_HDR1;
            res_o.valid           = 1'b1;
            res_o.item.frame_end  = 1'b1;
            res_o.item.error_code = ERR_UNMASKED;
          end else begin
            rlen_d = '0;
            rovf_d = 1'b0;
            key_d  = 32'd0;
            if (b[6:0] <= SHORT_LEN_MAX) begin
              rlen_d    = MaxLenW'(b[6:0]);
              len_known = 1'b1;
            end else begin
              phase_d = PH_EXTLEN;
              hcnt_d  = (b[6:0] == EXT16_CODE) ? EXT16_CNT : EXT64_CNT;
            end
          end
        end
        PH_EXTLEN: begin
          // Bits shifted out above the limit width only matter as a flag.
          rovf_d = rovf_d | (rlen_d[MaxLenW-1 -: 8] != 8'd0);
          rlen_d = {rlen_d[MaxLenW-9:0], b};
          if (hcnt_d == 3'd0) begin
            len_known = 1'b1;
          end else begin
            hcnt_d = hcnt_d - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_d[23:0], b};
          if (hcnt_d == 3'd0) begin
            start_pay = 1'b1;
          end else begin
            hcnt_d = hcnt_d - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          if (masked_d) begin
            case (midx_d)
              2'd0:    kbyte = key_d[31:24];
              2'd1:    kbyte = key_d[23:16];
              2'd2:    kbyte = key_d[15:8];
              default: kbyte = key_d[7:0];
            endcase
          end
          midx_d = midx_d + 2'd1;
          rlen_d = rlen_d - MaxLenW'(1);
          if (rlen_d == '0) begin
            phase_d = PH_HDR1;
          end
          res_o.valid             = 1'b1;
          res_o.item.payload_byte = b ^ kbyte;
          res_o.item.data_valid   = 1'b1;
          res_o.item.frame_end    = (rlen_d == '0);
        end
        default: begin
          fin_d = b[7];
          opc_d = b[3:0];
          if (b[3:0] == 4'd0 && b[7]) begin
            opc_d = mtype_d;
          end else if (b[3:0] != 4'd0 && !b[3] && !b[7]) begin
            mtype_d = b[3:0];
          end
          phase_d = PH_HDR2;
        end
      endcase

      // Frame length known: check the limit and book the message length.
      if (len_known) begin
        msg_sum  = SumW'(mlen_d) + SumW'(rlen_d);
        too_long = rovf_d || (rlen_d > max_len_q);
        if (!opc_d[3]) begin
          too_long = too_long || (msg_sum > SumW'(max_len_q));
        end
        if (too_long) begin
          closed_d              = 1'b1;
          phase_d               = PH_HDR1;
          res_o.valid           = 1'b1;
          res_o.item.frame_end  = 1'b1;
          res_o.item.error_code = ERR_TOO_LONG;
        end else begin
          if (!opc_d[3]) begin
            if (fin_d) begin
              mlen_d  = '0;
              mtype_d = 4'd0;
            end else begin
              mlen_d = msg_sum[LEN_BITS-1:0];
            end
          end
          if (masked_d) begin
            phase_d = PH_MASK;
            hcnt_d  = KEY_CNT;
          end else begin
            start_pay = 1'b1;
          end
        end
      end

      // Header done: an empty frame ends at once with a marker.
      if (start_pay) begin
        midx_d = 2'd0;
        if (rlen_d == '0) begin
          phase_d              = PH_HDR1;
          res_o.valid          = 1'b1;
          res_o.item.frame_end = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end

    res_o.item.msg_opcode = opc_d;
    res_o.item.fin_flag   = fin_d;
    if (!accept_i) begin
      res_o.valid = 1'b0;
    end
  end

  // State update on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR1;
      hcnt_q   <= 3'd0;
      fin_q    <= 1'b0;
      opc_q    <= 4'd0;
      masked_q <= 1'b0;
      rlen_q   <= '0;
      rovf_q   <= 1'b0;
      key_q    <= 32'd0;
      midx_q   <= 2'd0;
      mtype_q  <= 4'd0;
      mlen_q   <= '0;
      closed_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      fin_q    <= fin_d;
      opc_q    <= opc_d;
      masked_q <= masked_d;
      rlen_q   <= rlen_d;
      rovf_q   <= rovf_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
      mtype_q  <= mtype_d;
      mlen_q   <= mlen_d;
      closed_q <= closed_d;
    end
  end

  // A dead connection produces nothing until a new one starts.
  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && closed_q && !item_i.new_connection) |-> !res_o.valid)
    else $error("result produced on a closed connection");

  // Every error closes the connection.
  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.error_code != ERR_NONE) |=> closed_q)
    else $error("error did not close the connection");

  // Payload bytes are only produced in the payload phase.
  a_data_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.data_valid) |-> (phase_q == PH_PAYLOAD && !closed_q))
    else $error("payload byte outside the payload phase");

endmodule
`default_nettype wire

### sv/websocket_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Deframes a client-to-server byte stream and unmasks its payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle while in_stall_o is low and
// registers each result that it gives. Every byte is parsed in the cycle it is
// accepted, against the header, length and key state held in the parser;
// the result goes into an output register backed by a one-entry skid
// register, so input bytes keep flowing while a result waits to be taken.
// in_stall_o rises only when both output registers are full. Configuration
// writes are applied at once and must be made while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_receiver import wsfr_pkg::*; #(
  parameter int unsigned LEN_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [MaxLenW-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire wsfr_in_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output wsfr_out_t               out_item_o
);

  logic      in_accept;
  logic      out_take;
  wsfr_res_t res;

  logic      out_valid_q;
  wsfr_out_t out_item_q;
  logic      skid_valid_q;
  wsfr_out_t skid_item_q;

  // Input transfer when the skid register has room.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  wsfr_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_accept),
    .item_i     (in_item_i),
    .res_o      (res)
  );

  // Output register and skid register, in order of arrival.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= res.valid;
    end else if (res.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_item_q <= skid_item_q;
      end
    end else if (!out_valid_q || out_take) begin
      if (res.valid) begin
        out_item_q <= res.item;
      end
    end else if (res.valid) begin
      skid_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result ahead of the output register");

  // A result arriving at a stalled full output goes to the skid register.
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_valid_q && res.valid) |=> skid_valid_q)
    else $error("result lost at a stalled output");

  // No byte is parsed while the skid register is full.
  a_no_parse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res.valid)
    else $error("result produced while both output registers are full");

endmodule
`default_nettype wire
